// ===== design/tec_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and byte helpers for the tab-expanding UTF-8 column renderer.
// Used by the front, the item queue, the render engine and the top level.
package tec_pkg;

    localparam int MAX_COLUMNS_DEF = 4096;
    localparam int QUEUE_DEPTH     = 4;
    localparam int MAX_TAB         = 8;

    localparam logic [3:0]  TAB_WIDTH_RESET = 4'd4;
    localparam logic [11:0] OFF_CAP         = 12'hFFF;

    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_GT    = 8'h3E;
    localparam logic [7:0] CHAR_C     = 8'h43;
    localparam logic [7:0] CHAR_E     = 8'h45;
    localparam logic [7:0] CHAR_F     = 8'h46;
    localparam logic [7:0] CHAR_L     = 8'h4C;
    localparam logic [7:0] CHAR_O     = 8'h4F;
    localparam logic [7:0] CHAR_R     = 8'h52;

    // configuration register indexes
    localparam logic REG_TAB_WIDTH   = 1'b0;
    localparam logic REG_SHOW_HIDDEN = 1'b1;

    typedef enum logic [1:0] {
        MARK_NONE,
        MARK_LF,
        MARK_CRLF,
        MARK_EOF
    } marker_t;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] text;
        logic       line_done;
        marker_t    end_marker;
    } item_t;

    typedef struct packed {
        logic [3:0] tab_width;
        logic       show_hidden;
    } cfg_t;

    // UTF-8 sequence length announced by a lead byte
    function automatic logic [2:0] seq_len(input logic [7:0] b);
        logic [2:0] len;
        if (b < 8'h80)
            len = 3'd1;
        else if (b < 8'hE0)
            len = 3'd2;
        else if (b < 8'hF0)
            len = 3'd3;
        else
            len = 3'd4;
        return len;
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return (b & 8'hC0) == 8'h80;
    endfunction

    function automatic logic [11:0] sat_off(input logic [11:0] v, input logic [1:0] k);
        logic [12:0] s;
        s = {1'b0, v} + {11'd0, k};
        return (s > {1'b0, OFF_CAP}) ? OFF_CAP : s[11:0];
    endfunction

    function automatic logic [2:0] marker_len(input marker_t m);
        logic [2:0] len;
        unique case (m)
            MARK_LF:   len = 3'd3;
            MARK_CRLF: len = 3'd5;
            MARK_EOF:  len = 3'd4;
            default:   len = 3'd0;
        endcase
        return len;
    endfunction

    // bytes of " LF", " CRLF" and " EOF"
    function automatic logic [7:0] marker_char(input marker_t m, input logic [2:0] idx);
        logic [7:0] c;
        c = CHAR_SPACE;
        unique case (m)
            MARK_LF: begin
                if (idx == 3'd1)
                    c = CHAR_L;
                else if (idx == 3'd2)
                    c = CHAR_F;
            end
            MARK_CRLF: begin
                if (idx == 3'd1)
                    c = CHAR_C;
                else if (idx == 3'd2)
                    c = CHAR_R;
                else if (idx == 3'd3)
                    c = CHAR_L;
                else if (idx == 3'd4)
                    c = CHAR_F;
            end
            MARK_EOF: begin
                if (idx == 3'd1)
                    c = CHAR_E;
                else if (idx == 3'd2)
                    c = CHAR_O;
                else if (idx == 3'd3)
                    c = CHAR_F;
            end
            default: c = CHAR_SPACE;
        endcase
        return c;
    endfunction

endpackage

// ===== design/tec_front.sv =====
`timescale 1ns / 1ps
// Input side: accepts stream items, drops those that carry neither byte nor line end,
// and packs the rest for the item queue. Depends on tec_pkg.
module tec_front
    import tec_pkg::*;
(
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // text_in
    input  logic [2:0] s_tuser,   // has_byte, end_marker[1:0]
    input  logic       s_tlast,   // line_done
    input  logic       q_full,
    output logic       q_push,
    output item_t      q_item
);

    assign s_tready = !q_full;

    always_comb
    begin
        q_item.has_byte   = s_tuser[0];
        q_item.text       = s_tdata;
        q_item.line_done  = s_tlast;
        q_item.end_marker = marker_t'(s_tuser[2:1]);
        // an item with no byte and no line end renders nothing: drop it here
        q_push = s_tvalid && !q_full && (s_tuser[0] || s_tlast);
    end

endmodule

// ===== design/tec_queue.sv =====
`timescale 1ns / 1ps
// Short item queue between the front and the render engine.
// Depends on tec_pkg for the item type and depth.
module tec_queue
    import tec_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output logic  full,
    output logic  valid,
    output item_t head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t              mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full  = count_reg == CNT_W'(QUEUE_DEPTH);
    assign valid = count_reg != '0;
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== design/tec_back.sv =====
`timescale 1ns / 1ps
// Render engine: UTF-8 sequence tracking, tab runs, line-end markers and column counting,
// at most one result per cycle, into an output register held on stall. Depends on tec_pkg.
module tec_back
    import tec_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        q_valid,
    input  item_t       q_item,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // text_out[7:0], column[11:0], source_offset[11:0]
    output logic [1:0]  m_tuser,  // is_text, is_marker
    output logic        m_tlast   // line_end
);

    localparam int COL_CAP_INT = (MAX_COLUMNS - 1 < 4095) ? MAX_COLUMNS - 1 : 4095;
    localparam logic [11:0] COL_CAP = 12'(COL_CAP_INT);

    typedef enum logic [2:0] {
        S_LOAD,
        S_RUN,
        S_TAB,
        S_SEQ,
        S_MARK,
        S_FINAL
    } state_t;

    state_t      state_reg, state_next;
    logic [11:0] col_reg, col_next;
    logic [11:0] src_reg, src_next;
    logic [11:0] pstart_reg, pstart_next;
    logic [11:0] tab_off_reg, tab_off_next;
    logic [2:0]  phase_reg [MAX_TAB];
    logic [2:0]  phase_next [MAX_TAB];
    logic [7:0]  pbyte_reg [4];
    logic [7:0]  pbyte_next [4];
    logic [1:0]  pcount_reg, pcount_next;
    logic [2:0]  elen_reg, elen_next;
    logic [7:0]  wq_byte_reg [4];
    logic [7:0]  wq_byte_next [4];
    logic [11:0] wq_off_reg [4];
    logic [11:0] wq_off_next [4];
    logic [2:0]  wq_cnt_reg, wq_cnt_next;
    logic        done_reg, done_next;
    marker_t     mark_reg, mark_next;
    logic [3:0]  tab_left_reg, tab_left_next;
    logic        tab_first_reg, tab_first_next;
    logic [1:0]  seq_left_reg, seq_left_next;
    logic [2:0]  mark_idx_reg, mark_idx_next;

    logic        out_valid_reg, out_valid_next;
    logic        out_text_reg, out_text_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic [11:0] out_col_reg, out_col_next;
    logic [11:0] out_off_reg, out_off_next;
    logic        out_mark_reg, out_mark_next;
    logic        out_end_reg, out_end_next;

    logic        advance;
    logic        col_step;
    logic        pop_wq;
    logic        break_seq;
    logic [3:0]  tw;
    logic [3:0]  run;
    logic [7:0]  head_byte;
    logic [11:0] head_off;
    logic [2:0]  wq_sum;

    function automatic logic [11:0] sat_col(input logic [11:0] c, input logic [2:0] k);
        logic [12:0] s;
        s = {1'b0, c} + {10'd0, k};
        return (s > {1'b0, COL_CAP}) ? COL_CAP : s[11:0];
    endfunction

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_off_reg, out_col_reg, out_byte_reg};
    assign m_tuser  = {out_mark_reg, out_text_reg};
    assign m_tlast  = out_end_reg;

    assign advance   = !out_valid_reg || m_tready;
    assign head_byte = wq_byte_reg[0];
    assign head_off  = wq_off_reg[0];

    always_comb
    begin
        if (cfg.tab_width == 4'd0)
            tw = 4'd1;
        else if (cfg.tab_width > 4'd8)
            tw = 4'd8;
        else
            tw = cfg.tab_width;
        run = tw - {1'b0, phase_reg[3'(tw - 4'd1)]};
    end

    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        src_next       = src_reg;
        pstart_next    = pstart_reg;
        tab_off_next   = tab_off_reg;
        phase_next     = phase_reg;
        pbyte_next     = pbyte_reg;
        pcount_next    = pcount_reg;
        elen_next      = elen_reg;
        wq_byte_next   = wq_byte_reg;
        wq_off_next    = wq_off_reg;
        wq_cnt_next    = wq_cnt_reg;
        done_next      = done_reg;
        mark_next      = mark_reg;
        tab_left_next  = tab_left_reg;
        tab_first_next = tab_first_reg;
        seq_left_next  = seq_left_reg;
        mark_idx_next  = mark_idx_reg;

        out_valid_next = out_valid_reg && !m_tready;
        out_text_next  = out_text_reg;
        out_byte_next  = out_byte_reg;
        out_col_next   = out_col_reg;
        out_off_next   = out_off_reg;
        out_mark_next  = out_mark_reg;
        out_end_next   = out_end_reg;

        q_pop     = 1'b0;
        col_step  = 1'b0;
        pop_wq    = 1'b0;
        break_seq = 1'b0;
        wq_sum    = 3'd0;

        unique case (state_reg)
            S_LOAD: begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    done_next = q_item.line_done;
                    mark_next = q_item.end_marker;
                    if (q_item.has_byte)
                    begin
                        wq_byte_next[0] = q_item.text;
                        wq_off_next[0]  = src_reg;
                        wq_cnt_next     = 3'd1;
                        src_next        = sat_off(src_reg, 2'd1);
                    end
                    state_next = S_RUN;
                end
            end

            S_RUN: begin
                if (advance)
                begin
                    if (wq_cnt_reg != 3'd0)
                    begin
                        if (pcount_reg == 2'd0)
                        begin
                            pop_wq = 1'b1;
                            if (head_byte == CHAR_TAB)
                            begin
                                tab_left_next  = run;
                                tab_first_next = 1'b1;
                                tab_off_next   = head_off;
                                state_next     = S_TAB;
                            end
                            else if (seq_len(head_byte) == 3'd1)
                            begin
                                out_valid_next = 1'b1;
                                out_text_next  = 1'b1;
                                out_byte_next  = (cfg.show_hidden && head_byte == CHAR_SPACE) ?
                                                 CHAR_DOT : head_byte;
                                out_col_next   = col_reg;
                                out_off_next   = head_off;
                                out_mark_next  = 1'b0;
                                out_end_next   = 1'b0;
                                col_step       = 1'b1;
                            end
                            else
                            begin
                                // hold the lead until the sequence resolves
                                pbyte_next[0] = head_byte;
                                pcount_next   = 2'd1;
                                elen_next     = seq_len(head_byte);
                                pstart_next   = head_off;
                            end
                        end
                        else if (is_cont(head_byte))
                        begin
                            pop_wq                 = 1'b1;
                            pbyte_next[pcount_reg] = head_byte;
                            if ({1'b0, pcount_reg} + 3'd1 >= elen_reg)
                            begin
                                seq_left_next = pcount_reg;
                                state_next    = S_SEQ;
                            end
                            else
                                pcount_next = pcount_reg + 2'd1;
                        end
                        else
                            break_seq = 1'b1;
                    end
                    else if (done_reg)
                    begin
                        if (pcount_reg != 2'd0)
                            break_seq = 1'b1;
                        else if (cfg.show_hidden && mark_reg != MARK_NONE)
                        begin
                            mark_idx_next = 3'd0;
                            state_next    = S_MARK;
                        end
                        else
                            state_next = S_FINAL;
                    end
                    else
                        state_next = S_LOAD;
                end
            end

            S_TAB: begin
                if (advance)
                begin
                    out_valid_next = 1'b1;
                    out_text_next  = 1'b1;
                    out_byte_next  = (tab_first_reg && cfg.show_hidden) ? CHAR_GT : CHAR_SPACE;
                    out_col_next   = col_reg;
                    out_off_next   = tab_off_reg;
                    out_mark_next  = cfg.show_hidden;
                    out_end_next   = 1'b0;
                    col_step       = 1'b1;
                    tab_first_next = 1'b0;
                    if (tab_left_reg == 4'd1)
                        state_next = S_RUN;
                    else
                        tab_left_next = tab_left_reg - 4'd1;
                end
            end

            S_SEQ: begin
                if (advance)
                begin
                    out_valid_next = 1'b1;
                    out_text_next  = 1'b1;
                    out_byte_next  = pbyte_reg[0];
                    out_col_next   = col_reg;
                    out_off_next   = pstart_reg;
                    out_mark_next  = 1'b0;
                    out_end_next   = 1'b0;
                    pbyte_next[0]  = pbyte_reg[1];
                    pbyte_next[1]  = pbyte_reg[2];
                    pbyte_next[2]  = pbyte_reg[3];
                    if (seq_left_reg == 2'd0)
                    begin
                        col_step    = 1'b1;
                        pcount_next = 2'd0;
                        elen_next   = 3'd0;
                        state_next  = S_RUN;
                    end
                    else
                        seq_left_next = seq_left_reg - 2'd1;
                end
            end

            S_MARK: begin
                if (advance)
                begin
                    out_valid_next = 1'b1;
                    out_text_next  = 1'b1;
                    out_byte_next  = marker_char(mark_reg, mark_idx_reg);
                    out_col_next   = sat_col(col_reg, mark_idx_reg);
                    out_off_next   = src_reg;
                    out_mark_next  = 1'b1;
                    out_end_next   = 1'b0;
                    if (mark_idx_reg == marker_len(mark_reg) - 3'd1)
                        state_next = S_FINAL;
                    else
                        mark_idx_next = mark_idx_reg + 3'd1;
                end
            end

            S_FINAL: begin
                if (advance)
                begin
                    out_valid_next = 1'b1;
                    out_text_next  = 1'b0;
                    out_byte_next  = 8'd0;
                    out_col_next   = col_reg;
                    out_off_next   = src_reg;
                    out_mark_next  = 1'b0;
                    out_end_next   = 1'b1;
                    col_next       = 12'd0;
                    src_next       = 12'd0;
                    pcount_next    = 2'd0;
                    elen_next      = 3'd0;
                    pstart_next    = 12'd0;
                    for (int i = 0; i < MAX_TAB; i++)
                        phase_next[i] = 3'd0;
                    state_next = S_LOAD;
                end
            end

            default: state_next = S_LOAD;
        endcase

        if (pop_wq)
        begin
            for (int i = 0; i < 3; i++)
            begin
                wq_byte_next[i] = wq_byte_reg[i + 1];
                wq_off_next[i]  = wq_off_reg[i + 1];
            end
            wq_cnt_next = wq_cnt_reg - 3'd1;
        end

        // broken sequence: lead goes out alone, the held bytes are examined again
        if (break_seq)
        begin
            out_valid_next = 1'b1;
            out_text_next  = 1'b1;
            out_byte_next  = pbyte_reg[0];
            out_col_next   = col_reg;
            out_off_next   = pstart_reg;
            out_mark_next  = 1'b0;
            out_end_next   = 1'b0;
            col_step       = 1'b1;
            pcount_next    = 2'd0;
            elen_next      = 3'd0;
            wq_sum         = wq_cnt_reg + {1'b0, pcount_reg} - 3'd1;
            unique case (pcount_reg)
                2'd2: begin
                    wq_byte_next[0] = pbyte_reg[1];
                    wq_off_next[0]  = sat_off(pstart_reg, 2'd1);
                    for (int i = 1; i < 4; i++)
                    begin
                        wq_byte_next[i] = wq_byte_reg[i - 1];
                        wq_off_next[i]  = wq_off_reg[i - 1];
                    end
                end
                2'd3: begin
                    wq_byte_next[0] = pbyte_reg[1];
                    wq_off_next[0]  = sat_off(pstart_reg, 2'd1);
                    wq_byte_next[1] = pbyte_reg[2];
                    wq_off_next[1]  = sat_off(pstart_reg, 2'd2);
                    for (int i = 2; i < 4; i++)
                    begin
                        wq_byte_next[i] = wq_byte_reg[i - 2];
                        wq_off_next[i]  = wq_off_reg[i - 2];
                    end
                end
                default: ;
            endcase
            wq_cnt_next = (wq_sum > 3'd4) ? 3'd4 : wq_sum;
        end

        // column advance keeps one phase counter per tab width
        if (col_step && col_reg < COL_CAP)
        begin
            col_next = col_reg + 12'd1;
            for (int i = 0; i < MAX_TAB; i++)
                phase_next[i] = (phase_reg[i] == 3'(i)) ? 3'd0 : phase_reg[i] + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            col_reg       <= '0;
            src_reg       <= '0;
            pstart_reg    <= '0;
            for (int i = 0; i < MAX_TAB; i++)
                phase_reg[i] <= '0;
            pcount_reg    <= '0;
            elen_reg      <= '0;
            wq_cnt_reg    <= '0;
            done_reg      <= 1'b0;
            mark_reg      <= MARK_NONE;
            tab_left_reg  <= '0;
            tab_first_reg <= 1'b0;
            seq_left_reg  <= '0;
            mark_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_text_reg  <= 1'b0;
            out_byte_reg  <= '0;
            out_col_reg   <= '0;
            out_off_reg   <= '0;
            out_mark_reg  <= 1'b0;
            out_end_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            src_reg       <= src_next;
            pstart_reg    <= pstart_next;
            phase_reg     <= phase_next;
            pcount_reg    <= pcount_next;
            elen_reg      <= elen_next;
            wq_cnt_reg    <= wq_cnt_next;
            done_reg      <= done_next;
            mark_reg      <= mark_next;
            tab_left_reg  <= tab_left_next;
            tab_first_reg <= tab_first_next;
            seq_left_reg  <= seq_left_next;
            mark_idx_reg  <= mark_idx_next;
            out_valid_reg <= out_valid_next;
            out_text_reg  <= out_text_next;
            out_byte_reg  <= out_byte_next;
            out_col_reg   <= out_col_next;
            out_off_reg   <= out_off_next;
            out_mark_reg  <= out_mark_next;
            out_end_reg   <= out_end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pbyte_reg   <= pbyte_next;
        wq_byte_reg <= wq_byte_next;
        wq_off_reg  <= wq_off_next;
        tab_off_reg <= tab_off_next;
    end

    a_pending_short : assert property (@(posedge clk) disable iff (!rst_n)
        (pcount_reg != 2'd0) |-> (elen_reg >= 3'd2 && {1'b0, pcount_reg} < elen_reg))
        else $error("held sequence longer than its lead announced");

    a_replay_depth : assert property (@(posedge clk) disable iff (!rst_n)
        wq_cnt_reg <= 3'd3)
        else $error("replay queue overfilled");

    a_final_clean : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINAL) |-> (pcount_reg == 2'd0 && wq_cnt_reg == 3'd0))
        else $error("line closed with bytes still pending");

    a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> ($stable(col_reg) && $stable(pcount_reg)))
        else $error("engine advanced while output stalled");

endmodule

// ===== design/tab_expand_utf8_columns.sv =====
`timescale 1ns / 1ps
// With the engine idle, an accepted item is written into the queue, loaded by the render engine
// and, for a plain byte, rendered into the output register; a tab or a completed UTF-8 sequence
// passes through the tab or sequence state first. The engine renders one item at a time and
// gives at most one result per cycle; held bytes of a UTF-8 sequence give no result until it
// completes or breaks, and output stalls hold the engine.
// Reset (rst_n low, asynchronous) clears counters, queue, engine state; tab_width 4, show_hidden 0.
module tab_expand_utf8_columns
    import tec_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // text_in
    input  logic [2:0]  s_tuser,   // has_byte, end_marker[1:0]
    input  logic        s_tlast,   // line_done
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // text_out[7:0], column[11:0], source_offset[11:0]
    output logic [1:0]  m_tuser,   // is_text, is_marker
    output logic        m_tlast    // line_end
);

    logic [3:0] tab_width_reg;
    logic       show_hidden_reg;
    cfg_t       cfg;
    logic       q_full;
    logic       q_push;
    item_t      push_item;
    logic       q_valid;
    logic       q_pop;
    item_t      head_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tab_width_reg   <= TAB_WIDTH_RESET;
            show_hidden_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_TAB_WIDTH)
                tab_width_reg <= cfg_data;
            else if (cfg_index == REG_SHOW_HIDDEN)
                show_hidden_reg <= cfg_data[0];
        end
    end

    always_comb
    begin
        cfg.tab_width   = tab_width_reg;
        cfg.show_hidden = show_hidden_reg;
    end

    tec_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    tec_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .full      (q_full),
        .valid     (q_valid),
        .head      (head_item)
    );

    tec_back #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_item   (head_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== bench/tec_render_checker.sv =====
`timescale 1ns / 1ps
// Output checker for tab_expand_utf8_columns: follows register writes, predicts the rendered
// bytes of every accepted item and compares them with each accepted result, in order.
// Depends on tec_pkg for marker codes, register indexes and character constants.
module tec_render_checker
    import tec_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // text_in
    input  logic [2:0]  s_tuser,   // has_byte, end_marker[1:0]
    input  logic        s_tlast,   // line_done
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // text_out[7:0], column[11:0], source_offset[11:0]
    input  logic [1:0]  m_tuser,   // is_text, is_marker
    input  logic        m_tlast,   // line_end
    output int          errors,
    output int          glyphs_left
);

    localparam int COL_CAP = (MAX_COLUMNS - 1 < 4095) ? MAX_COLUMNS - 1 : 4095;
    localparam int OFFSET_CAP = 4095;
    localparam int RESULTS_PER_ITEM = 17;
    localparam int REPORT_LIMIT = 40;

    typedef struct packed {
        logic        is_text;
        logic [7:0]  text_out;
        logic [11:0] column;
        logic [11:0] source_offset;
        logic        is_marker;
        logic        line_end;
    } glyph_t;

    glyph_t glyphs_due[$];

    logic [3:0] tab_w = TAB_WIDTH_RESET;
    logic       show_hid = 1'b0;

    int col_cnt = 0;
    int src_cnt = 0;
    int pend_n = 0;
    int want_len = 0;
    int pend_start = 0;
    logic [7:0] pend_b [3];
    int step_n;

    // bytes waiting to be examined as new characters
    logic [7:0] q_byte [4];
    int q_off [4];
    int q_n;

    initial begin
        errors = 0;
        glyphs_left = 0;
    end

    function automatic int clip_col(input int v);
        return (v > COL_CAP) ? COL_CAP : v;
    endfunction

    function automatic int clip_off(input int v);
        return (v > OFFSET_CAP) ? OFFSET_CAP : v;
    endfunction

    function automatic int utf_len(input logic [7:0] b);
        if (b < 8'h80)
            return 1;
        if (b < 8'hE0)
            return 2;
        if (b < 8'hF0)
            return 3;
        return 4;
    endfunction

    function automatic void emit(input logic txt, input logic [7:0] b, input int col,
                                 input int off, input logic mk, input logic fin);
        glyph_t g;
        if (step_n >= RESULTS_PER_ITEM)
            return;
        g.is_text = txt;
        g.text_out = b;
        g.column = 12'(col);
        g.source_offset = 12'(off);
        g.is_marker = mk;
        g.line_end = fin;
        glyphs_due = {glyphs_due, g};
        step_n++;
    endfunction

    function automatic void expand_tab(input int off);
        int tw;
        int run;
        int k;
        tw = (tab_w == 4'd0) ? 1 : (tab_w > 4'd8) ? 8 : int'(tab_w);
        run = tw - (col_cnt % tw);
        for (k = 0; k < run; k++)
            emit(1'b1, (k == 0 && show_hid) ? CHAR_GT : CHAR_SPACE, clip_col(col_cnt + k), off,
                 show_hid, 1'b0);
        col_cnt = clip_col(col_cnt + run);
    endfunction

    function automatic void start_glyph(input logic [7:0] b, input int off);
        if (b == CHAR_TAB) begin
            expand_tab(off);
        end
        else if (utf_len(b) == 1) begin
            emit(1'b1, (show_hid && b == CHAR_SPACE) ? CHAR_DOT : b, col_cnt, off, 1'b0, 1'b0);
            col_cnt = clip_col(col_cnt + 1);
        end
        else begin
            pend_b[0] = b;
            pend_n = 1;
            want_len = utf_len(b);
            pend_start = off;
        end
    endfunction

    function automatic void lone_lead();
        emit(1'b1, pend_b[0], col_cnt, pend_start, 1'b0, 1'b0);
        col_cnt = clip_col(col_cnt + 1);
    endfunction

    // append held bytes from position first on to the scan queue
    function automatic void requeue_pending(input int first);
        int k;
        for (k = first; k < pend_n && k < 3; k++) begin
            q_byte[q_n] = pend_b[k];
            q_off[q_n] = clip_off(pend_start + k);
            q_n++;
        end
    endfunction

    function automatic void scan_queue();
        logic [7:0] tb [4];
        int to [4];
        int tn;
        int i;
        int j;
        int k;
        logic [7:0] b;
        i = 0;
        while (i < q_n) begin
            b = q_byte[i];
            if (pend_n == 0) begin
                start_glyph(b, q_off[i]);
                i++;
            end
            else if ((b & 8'hC0) == 8'h80) begin
                if (pend_n + 1 >= want_len) begin
                    for (k = 0; k < pend_n && k < 3; k++)
                        emit(1'b1, pend_b[k], col_cnt, pend_start, 1'b0, 1'b0);
                    emit(1'b1, b, col_cnt, pend_start, 1'b0, 1'b0);
                    col_cnt = clip_col(col_cnt + 1);
                    pend_n = 0;
                    want_len = 0;
                end
                else if (pend_n < 3) begin
                    pend_b[pend_n] = b;
                    pend_n++;
                end
                i++;
            end
            else begin
                // broken sequence: lead stands alone, the rest is scanned again
                lone_lead();
                tn = 0;
                for (k = 1; k < pend_n && k < 3 && tn < 4; k++) begin
                    tb[tn] = pend_b[k];
                    to[tn] = clip_off(pend_start + k);
                    tn++;
                end
                for (j = i; j < q_n && tn < 4; j++) begin
                    tb[tn] = q_byte[j];
                    to[tn] = q_off[j];
                    tn++;
                end
                pend_n = 0;
                want_len = 0;
                for (j = 0; j < tn; j++) begin
                    q_byte[j] = tb[j];
                    q_off[j] = to[j];
                end
                q_n = tn;
                i = 0;
            end
        end
    endfunction

    function automatic void take_item(input logic has, input logic [7:0] b, input logic done,
                                      input marker_t mark);
        string tail;
        int k;
        step_n = 0;
        if (has) begin
            q_n = 0;
            requeue_pending(0);
            q_byte[q_n] = b;
            q_off[q_n] = src_cnt;
            q_n++;
            pend_n = 0;
            want_len = 0;
            src_cnt = clip_off(src_cnt + 1);
            scan_queue();
        end
        if (done) begin
            // cut off whatever sequence is still open
            while (pend_n > 0) begin
                lone_lead();
                q_n = 0;
                requeue_pending(1);
                pend_n = 0;
                want_len = 0;
                scan_queue();
            end
            case (mark)
                MARK_LF:   tail = " LF";
                MARK_CRLF: tail = " CRLF";
                MARK_EOF:  tail = " EOF";
                default:   tail = "";
            endcase
            if (!show_hid)
                tail = "";
            for (k = 0; k < tail.len(); k++)
                emit(1'b1, tail[k], clip_col(col_cnt + k), src_cnt, 1'b1, 1'b0);
            emit(1'b0, 8'h00, col_cnt, src_cnt, 1'b0, 1'b1);
            col_cnt = 0;
            src_cnt = 0;
            pend_n = 0;
            want_len = 0;
            pend_start = 0;
        end
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk) begin : watch
        glyph_t got;
        glyph_t want;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                got.text_out = m_tdata[7:0];
                got.column = m_tdata[19:8];
                got.source_offset = m_tdata[31:20];
                got.is_text = m_tuser[0];
                got.is_marker = m_tuser[1];
                got.line_end = m_tlast;
                if (glyphs_due.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("%0t ns: no result expected, got %h", $time, got);
                end
                else begin
                    want = glyphs_due.pop_front();
                    check_field("is_text", want.is_text, got.is_text);
                    check_field("text_out", want.text_out, got.text_out);
                    check_field("column", want.column, got.column);
                    check_field("source_offset", want.source_offset, got.source_offset);
                    check_field("is_marker", want.is_marker, got.is_marker);
                    check_field("line_end", want.line_end, got.line_end);
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_TAB_WIDTH:   tab_w = cfg_data;
                    REG_SHOW_HIDDEN: show_hid = cfg_data[0];
                    default:         ;
                endcase
            end
            if (s_tvalid && s_tready)
                take_item(s_tuser[0], s_tdata, s_tlast, marker_t'(s_tuser[2:1]));
            glyphs_left = glyphs_due.size();
        end
    end

endmodule

// ===== bench/tab_expand_utf8_columns_tb.sv =====
`timescale 1ns / 1ps
// Top of the tab_expand_utf8_columns bench: drives lines of text and register writes,
// stalls both channels at random and prints the verdict; tec_render_checker does the checks.
// Depends on tec_pkg, the block itself and bench/tec_render_checker.sv.
module tab_expand_utf8_columns_tb;
    import tec_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [3:0]  cfg_data = 4'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;   // text_in
    logic [2:0]  s_tuser = 3'd0;   // has_byte, end_marker[1:0]
    logic        s_tlast = 1'b0;   // line_done
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // text_out[7:0], column[11:0], source_offset[11:0]
    logic [1:0]  m_tuser;          // is_text, is_marker
    logic        m_tlast;          // line_end

    int errors;
    int glyphs_left;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int items_sent = 0;
    logic [7:0] line_bytes [$];

    tab_expand_utf8_columns dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    tec_render_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .errors     (errors),
        .glyphs_left(glyphs_left)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_item(input logic has, input logic [7:0] b, input logic done,
                             input marker_t mark);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = b;
        s_tuser = {mark, has};
        s_tlast = done;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        if (has || done)
            items_sent++;
    endtask

    // hold until every expected result is out, then let the engine settle
    task automatic wait_quiet();
        s_tvalid = 1'b0;
        while (glyphs_left != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    task automatic apply_setup(input logic [3:0] tab, input logic show);
        wait_quiet();
        cfg_we = 1'b1;
        cfg_index = REG_TAB_WIDTH;
        cfg_data = tab;
        @(negedge clk);
        cfg_index = REG_SHOW_HIDDEN;
        cfg_data = {3'($urandom_range(7)), show};
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic marker_t any_marker();
        return marker_t'($urandom_range(3));
    endfunction

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(63));
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        line_bytes = {line_bytes, b};
    endfunction

    // append one random character, well formed most of the time
    function automatic void add_char();
        int pick;
        int n;
        int k;
        logic [7:0] lead;
        pick = $urandom_range(99);
        if (pick < 20) begin
            add_byte(8'($urandom_range(127)));
        end
        else if (pick < 32) begin
            add_byte(CHAR_TAB);
        end
        else if (pick < 42) begin
            add_byte(CHAR_SPACE);
        end
        else if (pick < 80) begin
            if (pick < 54)
                lead = 8'($urandom_range(8'hC0, 8'hDF));
            else if (pick < 64)
                lead = 8'($urandom_range(8'hE0, 8'hEF));
            else
                lead = 8'($urandom_range(8'hC0, 8'hFF));
            n = (lead < 8'hE0) ? 1 : (lead < 8'hF0) ? 2 : 3;
            // cut the sequence short now and then
            if (pick >= 72)
                n = $urandom_range(n - 1);
            add_byte(lead);
            for (k = 0; k < n; k++)
                add_byte(cont_byte());
        end
        else if (pick < 88) begin
            add_byte(cont_byte());
        end
        else begin
            add_byte(8'($urandom_range(255)));
        end
    endfunction

    task automatic send_line();
        int chars;
        int i;
        logic fold;
        line_bytes.delete();
        chars = $urandom_range(12);
        for (i = 0; i < chars; i++)
            add_char();
        fold = (line_bytes.size() != 0) && ($urandom_range(1) == 1);
        for (i = 0; i < line_bytes.size(); i++) begin
            // ignored noise between bytes
            if ($urandom_range(9) == 0)
                send_item(1'b0, 8'($urandom_range(255)), 1'b0, any_marker());
            send_item(1'b1, line_bytes[i], fold && (i == line_bytes.size() - 1), any_marker());
        end
        if (!fold)
            send_item(1'b0, 8'($urandom_range(255)), 1'b1, any_marker());
    endtask

    task automatic run_phase(input int idle, input int stall, input int count,
                             input logic [3:0] tab, input logic show);
        int first;
        logic paused;
        apply_setup(tab, show);
        send_idle_pct = idle;
        stall_pct = stall;
        first = items_sent;
        paused = 1'b0;
        while (items_sent - first < count) begin
            if (!paused && items_sent - first >= count / 2) begin
                wait_quiet();
                paused = 1'b1;
            end
            send_line();
        end
        send_idle_pct = 0;
        stall_pct = 0;
    endtask

    initial begin
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset setup: tab stops every 4, hidden characters off
        send_item(1'b1, 8'h41, 1'b0, MARK_NONE);
        send_item(1'b1, CHAR_TAB, 1'b0, MARK_NONE);
        send_item(1'b1, 8'h00, 1'b0, MARK_NONE);
        send_item(1'b1, 8'h7F, 1'b0, MARK_NONE);
        send_item(1'b1, 8'hFF, 1'b0, MARK_NONE);
        send_item(1'b1, 8'h80, 1'b0, MARK_NONE);
        send_item(1'b1, 8'hBF, 1'b0, MARK_NONE);
        send_item(1'b1, 8'h80, 1'b0, MARK_NONE);
        send_item(1'b0, 8'hFF, 1'b0, MARK_EOF);
        send_item(1'b1, CHAR_SPACE, 1'b1, MARK_LF);

        // tab width zero acts as one; line cut inside a three-byte sequence
        apply_setup(4'd0, 1'b1);
        send_item(1'b1, CHAR_TAB, 1'b0, MARK_NONE);
        send_item(1'b1, CHAR_SPACE, 1'b0, MARK_NONE);
        send_item(1'b1, 8'hC2, 1'b0, MARK_NONE);
        send_item(1'b1, 8'hA9, 1'b0, MARK_NONE);
        send_item(1'b1, 8'hE2, 1'b0, MARK_NONE);
        send_item(1'b1, 8'h82, 1'b1, MARK_CRLF);
        send_item(1'b0, 8'h00, 1'b1, MARK_NONE);

        // tab width above eight acts as eight; broken lead, stray continuation
        apply_setup(4'hF, 1'b1);
        send_item(1'b1, 8'h78, 1'b0, MARK_NONE);
        send_item(1'b1, CHAR_TAB, 1'b0, MARK_NONE);
        send_item(1'b1, 8'hE0, 1'b0, MARK_NONE);
        send_item(1'b1, 8'h41, 1'b0, MARK_NONE);
        send_item(1'b1, 8'h80, 1'b0, MARK_NONE);
        send_item(1'b1, 8'hF0, 1'b0, MARK_NONE);
        send_item(1'b1, 8'h90, 1'b0, MARK_NONE);
        send_item(1'b1, 8'h80, 1'b0, MARK_NONE);
        send_item(1'b1, 8'h80, 1'b0, MARK_NONE);
        send_item(1'b0, 8'h00, 1'b1, MARK_EOF);

        // back-to-back tab runs, then sequences broken and cut at the line end
        apply_setup(4'd8, 1'b1);
        repeat (12) send_item(1'b1, CHAR_TAB, 1'b0, MARK_NONE);
        send_item(1'b1, 8'hE2, 1'b0, MARK_NONE);
        send_item(1'b1, 8'h82, 1'b0, MARK_NONE);
        send_item(1'b1, 8'h78, 1'b0, MARK_NONE);
        send_item(1'b1, 8'hF0, 1'b0, MARK_NONE);
        send_item(1'b1, 8'h9F, 1'b0, MARK_NONE);
        send_item(1'b1, 8'h98, 1'b0, MARK_NONE);
        send_item(1'b1, 8'h80, 1'b0, MARK_NONE);
        send_item(1'b1, 8'hC3, 1'b1, MARK_CRLF);

        run_phase(0, 0, 68, 4'd1, 1'b0);
        run_phase(71, 0, 68, 4'd8, 1'b1);
        run_phase(0, 71, 68, 4'($urandom_range(2, 7)), 1'b0);
        run_phase(29, 29, 68, 4'($urandom_range(1, 8)), 1'b1);

        s_tvalid = 1'b0;
        wait_quiet();
        if (errors == 0 && glyphs_left == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
design/tec_pkg.sv
design/tec_front.sv
design/tec_queue.sv
design/tec_back.sv
design/tab_expand_utf8_columns.sv
bench/tec_render_checker.sv
bench/tab_expand_utf8_columns_tb.sv
